// ----- src/ipom_pkg.sv -----
// Package for the interleaved pixel order map: constants, sizes and the sequencer state type.
// No dependencies; used by src/interleaved_pixel_order_map.sv.
package ipom_pkg;

    localparam int STRIDE_DEFAULT = 100;
    localparam int DIM_W          = 14;
    localparam int SUM_W          = 28;
    localparam int INDEX_W        = 64;
    localparam int CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_TOTAL,
        ST_MOD,
        ST_SEARCH,
        ST_SEARCH_WAIT,
        ST_START,
        ST_START_WAIT,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ----- src/interleaved_pixel_order_map.sv -----
// Interleaved pixel order map: sample index to pixel coordinates.
// A query runs the index wrap (ST_TOTAL, ST_MOD), the table search (ST_SEARCH,
// ST_SEARCH_WAIT), the start states (ST_START, ST_START_WAIT), the divide (ST_DIV) and
// the output state (ST_OUT); a zero pixel total goes from the wrap straight to ST_OUT.
// A query after reset or a register write first refills the tables. One query at a time;
// busy drops in the strobe cycle. The receiver cannot stall. Reset (rst_n, asynchronous,
// active low) sets width and height to 1024 and marks tables stale.
module interleaved_pixel_order_map #(
    parameter int STRIDE = ipom_pkg::STRIDE_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ipom_pkg::INDEX_W-1:0]      sample_index,
    input  logic                              cfg_we,
    input  logic [ipom_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ipom_pkg::DIM_W-1:0]        cfg_data,
    output logic                              done,
    output logic [ipom_pkg::DIM_W-1:0]        pixel_x,
    output logic [ipom_pkg::DIM_W-1:0]        pixel_y
);

    localparam int GROUPS = STRIDE * STRIDE;
    localparam int GW     = $clog2(GROUPS);
    localparam int SW     = $clog2(STRIDE);
    localparam int DW     = ipom_pkg::DIM_W;
    localparam int SUMW   = ipom_pkg::SUM_W;
    localparam int IW     = ipom_pkg::INDEX_W;
    localparam int MODW   = IW + 1;
    localparam logic [GW-1:0] LAST_GROUP = GW'(GROUPS - 1);
    localparam logic [SW-1:0] LAST_OFF   = SW'(STRIDE - 1);
    localparam logic [DW-1:0] STRIDE_D   = DW'(STRIDE);
    // Division by STRIDE is a reciprocal multiply; it is exact for operands below 2^DW.
    localparam int QSH = DW + SW;
    localparam int PW  = 2 * DW + 2;
    localparam logic [PW-1:0] RECIP = PW'((2 ** QSH + STRIDE - 1) / STRIDE);

    // Both tables live in memories with registered reads.
    logic [SUMW-1:0] cum_mem [GROUPS];
    logic [DW-1:0]   col_mem [STRIDE];
    logic [SUMW-1:0] cum_rd_reg;
    logic [DW-1:0]   col_rd_reg;
    logic            cum_we;
    logic [GW-1:0]   cum_waddr, cum_raddr;
    logic [SUMW-1:0] cum_wdata;
    logic            col_we;
    logic [SW-1:0]   col_waddr, col_raddr;
    logic [DW-1:0]   col_wdata;

    always_ff @(posedge clk)
    begin
        if (cum_we)
        begin
            cum_mem[cum_waddr] <= cum_wdata;
        end
        cum_rd_reg <= cum_mem[cum_raddr];
        if (col_we)
        begin
            col_mem[col_waddr] <= col_wdata;
        end
        col_rd_reg <= col_mem[col_raddr];
    end

    ipom_pkg::state_t state_reg, state_next;
    logic [DW-1:0]   width_reg, height_reg;
    logic            valid_reg, valid_next;

    // Fill counters: column offset outer, row offset inner; running counts of spans.
    logic [SW-1:0]   gx_reg, gx_next, gy_reg, gy_next;
    logic [DW-1:0]   cx_reg, cx_next;       // columns for the current gx
    logic [DW-1:0]   cy_reg, cy_next;       // rows for the current gy
    logic [SUMW-1:0] sum_reg, sum_next;
    logic [GW-1:0]   gcnt_reg, gcnt_next;

    // Index wrap: restoring remainder, one bit a cycle.
    logic [IW-1:0]   idx_reg, idx_next;
    logic [SUMW:0]   rem_reg, rem_next;
    logic [SUMW-1:0] total_reg, total_next;
    logic [6:0]      cnt_reg, cnt_next;

    // Search bounds.
    logic [GW-1:0]   lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;

    // Local split: restoring divide by column count.
    logic [SUMW-1:0] quo_reg, quo_next;
    logic [DW:0]     drem_reg, drem_next;
    logic [DW-1:0]   px_reg, px_next, py_reg, py_next;
    logic            done_reg, done_next;

    logic [SUMW:0]   rem_sh;
    logic [DW:0]     drem_sh;
    logic [GW-1:0]   g_gx_full;

    logic [DW-1:0]   w_m1, h_m1, w_span, h_span;
    logic [PW-1:0]   w_prod, h_prod, g_prod;

    assign w_m1   = width_reg - 1'b1;
    assign h_m1   = height_reg - 1'b1;
    assign w_prod = PW'(w_m1) * RECIP;
    assign h_prod = PW'(h_m1) * RECIP;
    assign g_prod = PW'(lo_reg) * RECIP;
    assign w_span = (width_reg  == '0) ? '0 : DW'(w_prod >> QSH) + 1'b1;
    assign h_span = (height_reg == '0) ? '0 : DW'(h_prod >> QSH) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ipom_pkg::ST_IDLE;
            valid_reg  <= 1'b0;
            done_reg   <= 1'b0;
            width_reg  <= ipom_pkg::WIDTH_RESET;
            height_reg <= ipom_pkg::HEIGHT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
            if (cfg_we && cfg_index == ipom_pkg::REG_WIDTH)
            begin
                width_reg <= cfg_data;
                valid_reg <= 1'b0;
            end
            else if (cfg_we && cfg_index == ipom_pkg::REG_HEIGHT)
            begin
                height_reg <= cfg_data;
                valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        sum_reg   <= sum_next;
        gcnt_reg  <= gcnt_next;
        idx_reg   <= idx_next;
        rem_reg   <= rem_next;
        total_reg <= total_next;
        cnt_reg   <= cnt_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        quo_reg   <= quo_next;
        drem_reg  <= drem_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ipom_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = valid_reg ? ipom_pkg::ST_TOTAL : ipom_pkg::ST_FILL;
                end
            end
            ipom_pkg::ST_FILL:
            begin
                if (gcnt_reg == LAST_GROUP)
                begin
                    state_next = ipom_pkg::ST_TOTAL;
                end
            end
            ipom_pkg::ST_TOTAL:       state_next = ipom_pkg::ST_MOD;
            ipom_pkg::ST_MOD:
            begin
                // The total is loaded while the wrap count is zero and tested once the count is nonzero.
                if (cnt_reg != '0 && total_reg == '0)
                begin
                    state_next = ipom_pkg::ST_OUT;
                end
                else if (cnt_reg == 7'(MODW - 1))
                begin
                    state_next = ipom_pkg::ST_SEARCH;
                end
            end
            ipom_pkg::ST_SEARCH:
            begin
                state_next = (lo_reg < hi_reg) ? ipom_pkg::ST_SEARCH_WAIT
                                               : ipom_pkg::ST_START;
            end
            ipom_pkg::ST_SEARCH_WAIT: state_next = ipom_pkg::ST_SEARCH;
            ipom_pkg::ST_START:       state_next = ipom_pkg::ST_START_WAIT;
            ipom_pkg::ST_START_WAIT:  state_next = ipom_pkg::ST_DIV;
            ipom_pkg::ST_DIV:
            begin
                if (cnt_reg == 7'(SUMW - 1))
                begin
                    state_next = ipom_pkg::ST_OUT;
                end
            end
            ipom_pkg::ST_OUT:         state_next = ipom_pkg::ST_IDLE;
            default:                  state_next = ipom_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        valid_next = valid_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        sum_next   = sum_reg;
        gcnt_next  = gcnt_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        cnt_next   = cnt_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        quo_next   = quo_reg;
        drem_next  = drem_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        done_next  = 1'b0;
        cum_we     = 1'b0;
        cum_waddr  = gcnt_reg;
        cum_wdata  = '0;
        col_we     = 1'b0;
        col_waddr  = gx_reg;
        col_wdata  = cx_reg;
        cum_raddr  = mid_reg;
        col_raddr  = '0;
        rem_sh     = {rem_reg[SUMW-1:0], idx_reg[IW-1]};
        drem_sh    = {drem_reg[DW-1:0], quo_reg[SUMW-1]};
        g_gx_full  = '0;
        case (state_reg)
            ipom_pkg::ST_IDLE:
            begin
                idx_next  = sample_index;
                gx_next   = '0;
                gy_next   = '0;
                gcnt_next = '0;
                sum_next  = '0;
                // A span count is ceil((extent - offset) / STRIDE); it drops by one once
                // the offset passes the extent's residue, so count down from offset zero.
                cx_next   = w_span;
                cy_next   = h_span;
            end
            ipom_pkg::ST_FILL:
            begin
                cum_we    = 1'b1;
                cum_wdata = sum_reg + SUMW'(cx_reg) * SUMW'(cy_reg);
                sum_next  = cum_wdata;
                col_we    = (gy_reg == '0);
                gcnt_next = gcnt_reg + 1'b1;
                if (gy_reg == LAST_OFF)
                begin
                    gy_next = '0;
                    gx_next = gx_reg + 1'b1;
                    cy_next = h_span;
                    // The offset equals the residue when offset + (count - 1) * STRIDE
                    // reaches extent - 1.
                    if (cx_reg != '0 && DW'(gx_reg) + (cx_reg - 1'b1) * STRIDE_D == w_m1)
                    begin
                        cx_next = cx_reg - 1'b1;
                    end
                end
                else
                begin
                    gy_next = gy_reg + 1'b1;
                    if (cy_reg != '0 && DW'(gy_reg) + (cy_reg - 1'b1) * STRIDE_D == h_m1)
                    begin
                        cy_next = cy_reg - 1'b1;
                    end
                end
                if (gcnt_reg == LAST_GROUP)
                begin
                    valid_next = 1'b1;
                end
            end
            ipom_pkg::ST_TOTAL:
            begin
                cum_raddr = LAST_GROUP;
                rem_next  = '0;
                cnt_next  = '0;
            end
            ipom_pkg::ST_MOD:
            begin
                cum_raddr = LAST_GROUP;
                total_next = cum_rd_reg;
                if (cnt_reg == '0)
                begin
                    total_next = cum_rd_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    rem_next   = '0;
                    if (cum_rd_reg == '0)
                    begin
                        total_next = '0;
                    end
                end
                else
                begin
                    total_next = total_reg;
                    rem_next   = (rem_sh >= {1'b0, total_reg}) ? rem_sh - {1'b0, total_reg}
                                                              : rem_sh;
                    idx_next   = {idx_reg[IW-2:0], 1'b0};
                    cnt_next   = cnt_reg + 1'b1;
                end
                px_next = '0;
                py_next = '0;
                lo_next = '0;
                hi_next = LAST_GROUP;
                mid_next = LAST_GROUP >> 1;
            end
            ipom_pkg::ST_SEARCH:
            begin
                cum_raddr = mid_reg;
            end
            ipom_pkg::ST_SEARCH_WAIT:
            begin
                if (rem_reg[SUMW-1:0] < cum_rd_reg)
                begin
                    hi_next  = mid_reg;
                    mid_next = GW'(({1'b0, lo_reg} + {1'b0, mid_reg}) >> 1);
                end
                else
                begin
                    lo_next  = mid_reg + 1'b1;
                    mid_next = GW'(({1'b0, mid_reg} + 1'b1 + {1'b0, hi_reg}) >> 1);
                end
            end
            ipom_pkg::ST_START:
            begin
                cum_raddr = (lo_reg == '0) ? '0 : lo_reg - 1'b1;
                g_gx_full = GW'(g_prod >> QSH);
                col_raddr = SW'(g_gx_full);
                px_next   = DW'(g_gx_full);
            end
            ipom_pkg::ST_START_WAIT:
            begin
                py_next   = DW'(lo_reg) - px_reg * STRIDE_D;
                quo_next  = rem_reg[SUMW-1:0] - ((lo_reg == '0) ? '0 : cum_rd_reg);
                drem_next = '0;
                cnt_next  = '0;
            end
            ipom_pkg::ST_DIV:
            begin
                drem_next = (drem_sh >= {1'b0, col_rd_reg}) ? drem_sh - {1'b0, col_rd_reg}
                                                           : drem_sh;
                quo_next  = {quo_reg[SUMW-2:0], (drem_sh >= {1'b0, col_rd_reg})};
                cnt_next  = cnt_reg + 1'b1;
            end
            ipom_pkg::ST_OUT:
            begin
                done_next = 1'b1;
                if (total_reg != '0)
                begin
                    px_next = DW'(px_reg + drem_reg[DW-1:0] * STRIDE_D);
                    py_next = DW'(py_reg + quo_reg[DW-1:0] * STRIDE_D);
                end
                else
                begin
                    px_next = '0;
                    py_next = '0;
                end
            end
            default: ;
        endcase
        col_raddr = (state_reg == ipom_pkg::ST_START) ? SW'(g_gx_full) : SW'(px_reg);
    end

    assign busy    = (state_reg != ipom_pkg::ST_IDLE);
    assign done    = done_reg;
    assign pixel_x = px_reg;
    assign pixel_y = py_reg;

endmodule

// ----- bench/testbench.sv -----
// Testbench for interleaved_pixel_order_map: drives sample indexes over several image sizes
// and checks each pixel against a self-contained predictor. Depends on src/ipom_pkg.sv.
module testbench;
    import ipom_pkg::*;

    localparam int STRIDE = STRIDE_DEFAULT;
    localparam int GROUPS = STRIDE * STRIDE;

    typedef struct {
        logic [DIM_W-1:0] px;
        logic [DIM_W-1:0] py;
    } pixel_t;

    class pixel_scoreboard;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        bit stale;
        logic [SUM_W-1:0] cum_sizes [GROUPS];
        int unsigned col_counts [STRIDE];
        pixel_t pending [$];
        int errors;
        int checked;

        function new();
            width = WIDTH_RESET;
            height = HEIGHT_RESET;
            stale = 1;
            errors = 0;
            checked = 0;
        endfunction

        function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            if (idx == REG_WIDTH)
                width = val;
            else if (idx == REG_HEIGHT)
                height = val;
            stale = 1;
        endfunction

        static function int unsigned spans(int unsigned extent, int unsigned offset);
            if (offset >= extent)
                return 0;
            return (extent - 1 - offset) / STRIDE + 1;
        endfunction

        function void refill();
            int unsigned sum;
            int unsigned cx;
            sum = 0;
            for (int gx = 0; gx < STRIDE; gx++)
            begin
                cx = spans(width, gx);
                col_counts[gx] = cx;
                for (int gy = 0; gy < STRIDE; gy++)
                begin
                    sum += cx * spans(height, gy);
                    cum_sizes[gx * STRIDE + gy] = sum;
                end
            end
            stale = 0;
        endfunction

        function int unsigned pixel_total();
            if (stale)
                refill();
            return cum_sizes[GROUPS-1];
        endfunction

        // Records one accepted query together with the pixel it must map to.
        function void note_query(logic [INDEX_W-1:0] idx);
            pixel_t p;
            int unsigned total;
            int unsigned pos;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            int unsigned local_off;
            int unsigned gx;
            int unsigned gy;
            int unsigned cx;
            int unsigned tx;
            int unsigned ty;
            total = pixel_total();
            p.px = '0;
            p.py = '0;
            if (total != 0)
            begin
                pos = int'(longint'(idx % 64'(total)));
                lo = 0;
                hi = GROUPS - 1;
                while (lo < hi)
                begin
                    mid = (lo + hi) >> 1;
                    if (pos < cum_sizes[mid])
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                local_off = pos - ((lo == 0) ? 0 : cum_sizes[lo-1]);
                gx = lo / STRIDE;
                gy = lo % STRIDE;
                cx = col_counts[gx];
                tx = 0;
                ty = 0;
                if (cx != 0)
                begin
                    tx = local_off % cx;
                    ty = local_off / cx;
                end
                p.px = DIM_W'(gx + tx * STRIDE);
                p.py = DIM_W'(gy + ty * STRIDE);
            end
            pending.push_back(p);
        endfunction

        function void check_pixel(logic [DIM_W-1:0] px, logic [DIM_W-1:0] py);
            pixel_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer: pixel_x %0d pixel_y %0d", px, py);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (px !== e.px)
            begin
                $error("pixel_x mismatch: expected %0d, actual %0d", e.px, px);
                errors++;
            end
            if (py !== e.py)
            begin
                $error("pixel_y mismatch: expected %0d, actual %0d", e.py, py);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [INDEX_W-1:0] sample_index = '0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;
    logic done;
    logic [DIM_W-1:0] pixel_x;
    logic [DIM_W-1:0] pixel_y;

    pixel_scoreboard sb = new();
    int sent = 0;
    int phases = 0;

    interleaved_pixel_order_map #(.STRIDE(STRIDE)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_index(sample_index), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .pixel_x(pixel_x), .pixel_y(pixel_y)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_pixel(pixel_x, pixel_y);
    end

    // Start stays high across back-to-back transfers when the gap is zero.
    task automatic send_query(logic [INDEX_W-1:0] idx);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        sample_index <= idx;
        do
            @(posedge clk);
        while (busy);
        sb.note_query(idx);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        sb.set_dim(REG_WIDTH, w);
        cfg_index <= REG_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        sb.set_dim(REG_HEIGHT, h);
        cfg_we <= 1'b0;
        @(posedge clk);
        phases++;
    endtask

    task automatic random_queries(int count);
        longint unsigned total;
        logic [INDEX_W-1:0] idx;
        total = sb.pixel_total();
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: idx = 64'($urandom_range(0, 1000));
                1: idx = 64'(total) * $urandom_range(0, 1000) + $urandom_range(0, 3)
                         - $urandom_range(0, 3);
                default: idx = {$urandom, $urandom};
            endcase
            send_query(idx);
        end
    endtask

    initial
    begin
        longint unsigned total;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed queries at the reset size: index extremes and wrap points.
        total = sb.pixel_total();
        send_query('0);
        send_query('1);
        send_query(64'(total) - 1);
        send_query(64'(total));
        send_query(64'(total) + 1);
        send_query(64'h8000_0000_0000_0000);
        send_query(64'h5555_5555_5555_5555);
        send_query(64'hAAAA_AAAA_AAAA_AAAA);
        random_queries(150);
        drain();

        // Size extremes, then random sizes.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin w = 100; h = 100; end
                1: begin w = 16383; h = 16383; end
                2: begin w = 100; h = 16383; end
                3: begin w = 16383; h = 100; end
                default:
                begin
                    w = $urandom_range(100, 16383);
                    h = $urandom_range(100, 16383);
                end
            endcase
            write_dims(w, h);
            total = sb.pixel_total();
            send_query('0);
            send_query(64'(total) - 1);
            send_query('1);
            random_queries(175);
            drain();
        end

        $display("Covered %0d queries over %0d register settings, %0d results checked.",
                 sent, phases + 1, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
